// ===== sv/pva_pkg.sv =====
// pva_pkg: shared types and constants for the voice allocator
// op and action codes, controller/datapath command and status structs
// no dependencies
package pva_pkg;

  // event codes carried by an input beat
  typedef enum logic [1:0] {
    OP_NOTE_ON    = 2'd0,
    OP_NOTE_OFF   = 2'd1,
    OP_ALL_OFF    = 2'd2,
    OP_VOICE_DONE = 2'd3
  } op_t;

  // what a note on did to its slot
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RETRIG = 2'd2,
    ACT_STEAL  = 2'd3
  } action_t;

  // velocity full scale, 1.0 in unsigned 1.7 fixed point
  localparam logic [7:0] VEL_FULL = 8'd128;

  // width that holds any slot count or slot number, and the reported ceiling
  localparam int         EXT_W    = 7;
  localparam logic [3:0] CNT_SAT  = 4'd15;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the input beat
    logic issue;   // read slot tables at rd_addr
    logic eval;    // evaluate the slot read last cycle
    logic commit;  // update slot state and load the result register
  } pva_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_op; // offered beat needs a slot scan
    logic stop;    // scan has reached its end
  } pva_stat_t;

endpackage

// ===== sv/pva_in_if.sv =====
// pva_in_if: input event channel, valid/ready with event payload
// depends on pva_pkg
interface pva_in_if import pva_pkg::*; ();
  logic       valid;
  logic       ready;
  op_t        op;
  logic [6:0] note;
  logic [7:0] velocity;
  logic [2:0] voice_id;

  modport source (output valid, output op, output note, output velocity,
                  output voice_id, input ready);
  modport sink   (input valid, input op, input note, input velocity,
                  input voice_id, output ready);
endinterface

// ===== sv/pva_out_if.sv =====
// pva_out_if: result channel, valid/ready with allocation result payload
// depends on pva_pkg
interface pva_out_if import pva_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] chosen_voice;
  action_t    action;
  logic [7:0] released_mask;
  logic [3:0] active_count;
  logic [7:0] voice_velocity;

  modport source (output valid, output chosen_voice, output action,
                  output released_mask, output active_count,
                  output voice_velocity, input ready);
  modport sink   (input valid, input chosen_voice, input action,
                  input released_mask, input active_count,
                  input voice_velocity, output ready);
endinterface

// ===== sv/pva_ctrl.sv =====
// pva_ctrl: sequencing state machine for the voice allocator
// owns the handshakes, the scan counter and the result valid flag; uses pva_pkg
module pva_ctrl import pva_pkg::*; #(
  parameter int  VOICE_COUNT = 8,
  localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1,
  localparam int CW = $clog2(VOICE_COUNT + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pva_cmd_t      cmd,
  output logic [IW-1:0] rd_addr,
  input  pva_stat_t     stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // next state, commands and scan address
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    rd_addr   = cnt_r[IW-1:0];
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.scan_op) begin
            cmd.issue = 1'b1;
            rd_addr   = '0;
            cnt_nxt   = CW'(1);
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        cmd.eval = 1'b1;
        if (cnt_r < CW'(VOICE_COUNT)) begin
          cmd.issue = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
        if (stat.stop) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan counter never runs past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= CW'(VOICE_COUNT)))
    else $error("scan counter beyond slot table");

  // a finished item waits in FIN while the result register is occupied
  a_fin_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result overwritten while still waiting");

  // a commit always presents a result beat
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result valid");

endmodule

// ===== sv/pva_dp.sv =====
// pva_dp: slot tables, scan evaluation, state update and result register
// note/age tables are memories read one slot a cycle; uses pva_pkg
module pva_dp import pva_pkg::*; #(
  parameter int  VOICE_COUNT = 8,
  localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1,
  localparam int CW = $clog2(VOICE_COUNT + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pva_cmd_t      cmd,
  input  logic [IW-1:0] rd_addr,
  output pva_stat_t     stat,
  input  op_t           in_op,
  input  logic [6:0]    in_note,
  input  logic [7:0]    in_velocity,
  input  logic [2:0]    in_voice_id,
  output logic [2:0]    res_chosen,
  output action_t       res_action,
  output logic [7:0]    res_mask,
  output logic [3:0]    res_count,
  output logic [7:0]    res_velocity
);

  // slot tables
  logic [6:0]  note_mem [VOICE_COUNT];
  logic [31:0] age_mem  [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] held_r, held_nxt;
  logic [VOICE_COUNT-1:0] active_r, active_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [31:0]            age_stamp_r;
  logic [31:0]            age_next;

  // latched item
  op_t        op_r;
  logic [6:0] note_r;
  logic [7:0] vel_r;
  logic [2:0] vid_r;

  // scan read stage and running picks
  logic          ev_valid_r;
  logic [IW-1:0] ev_idx_r;
  logic [6:0]    rd_note_r;
  logic [31:0]   rd_age_r;
  logic          rd_held_r;
  logic          rd_active_r;
  logic [IW-1:0] best_idx_r;
  logic [31:0]   best_age_r;
  logic [IW-1:0] pick_r;
  action_t       act_r;
  logic [VOICE_COUNT-1:0] rel_mask_r;

  logic                   is_on;
  logic                   note_hit;
  logic                   older;
  logic                   last_slot;
  logic                   vid_ok;
  logic [IW-1:0]          vid_idx;
  logic [VOICE_COUNT-1:0] mask_sel;
  logic [VOICE_COUNT+7:0] mask_pad;
  logic [IW+2:0]          pick_pad;
  logic [EXT_W-1:0]       cnt_ext;
  logic [3:0]             count_out;

  // slot evaluation for the beat read last cycle
  always_comb begin
    is_on        = (op_r == OP_NOTE_ON);
    note_hit     = rd_held_r && (rd_note_r == note_r);
    older        = (ev_idx_r == '0) || (rd_age_r < best_age_r);
    last_slot    = (ev_idx_r == IW'(VOICE_COUNT - 1));
    stat.scan_op = (in_op == OP_NOTE_ON) || (in_op == OP_NOTE_OFF);
    stat.stop    = ev_valid_r && ((is_on && (note_hit || !rd_active_r)) || last_slot);
    vid_ok       = (EXT_W'(vid_r) < EXT_W'(VOICE_COUNT));
    vid_idx      = IW'(vid_r);
    age_next     = age_stamp_r + 32'd1;
  end

  // held/active/count update at commit
  always_comb begin
    held_nxt   = held_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    mask_sel   = '0;
    if (cmd.commit) begin
      unique case (op_r)
        OP_NOTE_ON: begin
          held_nxt[pick_r]   = 1'b1;
          active_nxt[pick_r] = 1'b1;
          if (!active_r[pick_r]) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        OP_NOTE_OFF: begin
          held_nxt = held_r & ~rel_mask_r;
          mask_sel = rel_mask_r;
        end
        OP_ALL_OFF: begin
          held_nxt = '0;
          mask_sel = held_r;
        end
        OP_VOICE_DONE: begin
          if (vid_ok) begin
            active_nxt[vid_idx] = 1'b0;
            if (active_r[vid_idx]) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
      endcase
    end
  end

  // result formatting: slots past eight have no mask bit, count saturates
  always_comb begin
    mask_pad  = (VOICE_COUNT + 8)'(mask_sel);
    pick_pad  = (IW + 3)'(pick_r);
    cnt_ext   = EXT_W'(cnt_nxt);
    count_out = (cnt_ext > EXT_W'(CNT_SAT)) ? CNT_SAT : cnt_ext[3:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      active_r    <= '0;
      cnt_r       <= '0;
      age_stamp_r <= '0;
      ev_valid_r  <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      active_r   <= active_nxt;
      cnt_r      <= cnt_nxt;
      ev_valid_r <= cmd.issue;
      if (cmd.commit && is_on) begin
        age_stamp_r <= age_next;
      end
    end
  end

  // slot tables: write the chosen slot at commit, registered scan read
  always_ff @(posedge clk) begin
    if (cmd.commit && is_on) begin
      note_mem[pick_r] <= note_r;
      age_mem[pick_r]  <= age_next;
    end
    if (cmd.issue) begin
      rd_note_r   <= note_mem[rd_addr];
      rd_age_r    <= age_mem[rd_addr];
      rd_held_r   <= held_r[rd_addr];
      rd_active_r <= active_r[rd_addr];
      ev_idx_r    <= rd_addr;
    end
  end

  // item latch, scan picks and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      note_r     <= in_note;
      vel_r      <= (in_velocity > VEL_FULL) ? VEL_FULL : in_velocity;
      vid_r      <= in_voice_id;
      rel_mask_r <= '0;
    end
    if (cmd.eval && ev_valid_r) begin
      if (is_on) begin
        if (older) begin
          best_idx_r <= ev_idx_r;
          best_age_r <= rd_age_r;
        end
        if (stat.stop) begin
          priority if (note_hit) begin
            pick_r <= ev_idx_r;
            act_r  <= ACT_RETRIG;
          end else if (!rd_active_r) begin
            pick_r <= ev_idx_r;
            act_r  <= ACT_FREE;
          end else begin
            pick_r <= older ? ev_idx_r : best_idx_r;
            act_r  <= ACT_STEAL;
          end
        end
      end else if (note_hit) begin
        rel_mask_r[ev_idx_r] <= 1'b1;
      end
    end
    if (cmd.commit) begin
      res_chosen   <= is_on ? pick_pad[2:0] : 3'd0;
      res_action   <= is_on ? act_r : ACT_NONE;
      res_mask     <= mask_pad[7:0];
      res_count    <= count_out;
      res_velocity <= is_on ? vel_r : 8'd0;
    end
  end

  // running count tracks the active flags
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    EXT_W'(cnt_r) == EXT_W'($countones(active_r)))
    else $error("active count out of step with active flags");

  // stealing only happens with every slot busy
  a_steal_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_on && act_r == ACT_STEAL) |-> (&active_r))
    else $error("slot stolen while a free slot exists");

  // a note off only releases slots that were held
  a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && op_r == OP_NOTE_OFF) |-> ((rel_mask_r & ~held_r) == '0))
    else $error("note off released a slot that was not held");

endmodule

// ===== sv/polyphonic_voice_allocator_core.sv =====
// polyphonic_voice_allocator_core: oldest-voice-stealing slot allocator
// all notes off and voice finished skip the scan and go straight from the accepted beat to the result,
// a note on scans slots in order and stops at the first held match or free slot, a note off scans every slot
// the one-slot-a-cycle scan of the note/age memory runs through its single read port, and a new beat is
// taken only after the last one is committed; the result register lets the next beat in while it waits
// reset: synchronous active-low rst_n clears flags, count and age stamp; no clearing pass
module polyphonic_voice_allocator_core import pva_pkg::*; #(
  parameter int VOICE_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_chan,
  pva_out_if.source out_chan
);

  localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  pva_cmd_t      cmd;
  pva_stat_t     stat;
  logic [IW-1:0] rd_addr;

  // sequencer
  pva_ctrl #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .stat      (stat)
  );

  // slot tables and result register
  pva_dp #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .stat         (stat),
    .in_op        (in_chan.op),
    .in_note      (in_chan.note),
    .in_velocity  (in_chan.velocity),
    .in_voice_id  (in_chan.voice_id),
    .res_chosen   (out_chan.chosen_voice),
    .res_action   (out_chan.action),
    .res_mask     (out_chan.released_mask),
    .res_count    (out_chan.active_count),
    .res_velocity (out_chan.voice_velocity)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for polyphonic_voice_allocator_core
// keeps its own voice table to predict every result beat, checked against the dut
// depends on pva_pkg, pva_in_if, pva_out_if and the core
module testbench;
  import pva_pkg::*;

  localparam int VOICES       = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_WAIT  = 2 * VOICES + 10;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0] chosen_voice;
    action_t    action;
    logic [7:0] released_mask;
    logic [3:0] active_count;
    logic [7:0] voice_velocity;
  } voice_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pva_in_if  in_chan ();
  pva_out_if out_chan ();

  polyphonic_voice_allocator_core #(
    .VOICE_COUNT (VOICES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicted voice table, as left by reset
  logic [6:0]  voice_note   [VOICES] = '{default: 7'd60};
  bit          voice_held   [VOICES] = '{default: 1'b0};
  bit          voice_active [VOICES] = '{default: 1'b0};
  logic [31:0] voice_age    [VOICES] = '{default: 32'd0};
  logic [7:0]  voice_level  [VOICES] = '{default: 8'd0};
  logic [31:0] stamp_model = 32'd0;

  voice_result_t awaited_results[$];
  int            fail_count  = 0;
  int            burst_left  = 1;
  logic [7:0]    hold_token  = 8'd0;

  // receiver-side state, owned by the ready process
  logic [7:0] hold_seen   = 8'd0;
  int         hold_left   = 0;
  int         ready_mode  = 0;
  int         mode_left   = 0;
  int         ready_phase = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one event to the predicted table and work out its result beat
  function automatic voice_result_t predict_event(input op_t op, input logic [6:0] note,
                                                  input logic [7:0] vel,
                                                  input logic [2:0] vid);
    voice_result_t res;
    int            pick;
    int            oldest;
    int            live;
    bit            found;
    res    = '{chosen_voice: 3'd0, action: ACT_NONE, released_mask: 8'd0,
               active_count: 4'd0, voice_velocity: 8'd0};
    pick   = 0;
    oldest = 0;
    live   = 0;
    found  = 1'b0;
    case (op)
      OP_NOTE_ON: begin
        // same held note wins over a free slot within one slot
        for (int i = 0; i < VOICES; i++) begin
          if (!found) begin
            if (voice_note[i] == note && voice_held[i]) begin
              pick       = i;
              res.action = ACT_RETRIG;
              found      = 1'b1;
            end else if (!voice_active[i]) begin
              pick       = i;
              res.action = ACT_FREE;
              found      = 1'b1;
            end else if (voice_age[i] < voice_age[oldest]) begin
              oldest = i;
            end
          end
        end
        if (!found) begin
          pick       = oldest;
          res.action = ACT_STEAL;
        end
        if (vel > VEL_FULL) vel = VEL_FULL;
        stamp_model        = stamp_model + 32'd1;
        voice_note[pick]   = note;
        voice_held[pick]   = 1'b1;
        voice_active[pick] = 1'b1;
        voice_level[pick]  = vel;
        voice_age[pick]    = stamp_model;
        res.chosen_voice   = 3'(pick);
        res.voice_velocity = vel;
      end
      OP_NOTE_OFF: begin
        for (int i = 0; i < VOICES; i++) begin
          if (voice_note[i] == note && voice_held[i]) begin
            voice_held[i]        = 1'b0;
            res.released_mask[i] = 1'b1;
          end
        end
      end
      OP_ALL_OFF: begin
        for (int i = 0; i < VOICES; i++) begin
          res.released_mask[i] = voice_held[i];
          voice_held[i]        = 1'b0;
        end
      end
      default: begin
        if (int'(vid) < VOICES) voice_active[vid] = 1'b0;
      end
    endcase
    for (int i = 0; i < VOICES; i++) begin
      if (voice_active[i]) live++;
    end
    res.active_count = (live > 15) ? CNT_SAT : 4'(live);
    return res;
  endfunction

  // offer one event beat, log its prediction on acceptance, then maybe idle
  task automatic send_event(input op_t op, input logic [6:0] note, input logic [7:0] vel,
                            input logic [2:0] vid);
    int gap;
    in_chan.valid    <= 1'b1;
    in_chan.op       <= op;
    in_chan.note     <= note;
    in_chan.velocity <= vel;
    in_chan.voice_id <= vid;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    awaited_results.push_back(predict_event(op, note, vel, vid));
    burst_left--;
    if (burst_left <= 0) begin
      // a quarter of bursts run straight on into the next
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // stop offering and wait until every predicted beat has come back
  task automatic wait_for_idle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // result ready: long hold-offs on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(5, 80);
      end else begin
        mode_left--;
      end
      ready_phase++;
      case (ready_mode)
        0:       out_chan.ready <= 1'b1;
        1:       out_chan.ready <= 1'($urandom_range(0, 1));
        2:       out_chan.ready <= (ready_phase % 4 != 0);
        default: out_chan.ready <= (ready_phase % 5 == 0);
      endcase
    end
  end

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    voice_result_t seen;
    voice_result_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      seen = '{chosen_voice: out_chan.chosen_voice, action: out_chan.action,
               released_mask: out_chan.released_mask, active_count: out_chan.active_count,
               voice_velocity: out_chan.voice_velocity};
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: result beat with nothing awaited: voice %0d action %0d mask %h",
                   $realtime, seen.chosen_voice, seen.action, seen.released_mask);
      end else begin
        want = awaited_results.pop_front();
        if (seen.chosen_voice !== want.chosen_voice || seen.action !== want.action ||
            seen.released_mask !== want.released_mask ||
            seen.active_count !== want.active_count ||
            seen.voice_velocity !== want.voice_velocity) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: exp v%0d a%0d m%h n%0d vel%0d, got v%0d a%0d m%h n%0d vel%0d",
                     $realtime, want.chosen_voice, want.action, want.released_mask,
                     want.active_count, want.voice_velocity, seen.chosen_voice,
                     seen.action, seen.released_mask, seen.active_count,
                     seen.voice_velocity);
        end
      end
    end
  end

  // fill the table from reset: reset note value, retrigger, velocity extremes
  task automatic test_note_on_fill();
    send_event(OP_NOTE_ON, 7'd60,  8'd255, 3'd0);
    send_event(OP_NOTE_ON, 7'd60,  8'd100, 3'd7);
    send_event(OP_NOTE_ON, 7'd0,   8'd0,   3'd0);
    send_event(OP_NOTE_ON, 7'd127, 8'd128, 3'd7);
    send_event(OP_NOTE_ON, 7'd10,  8'd129, 3'd5);
    send_event(OP_NOTE_ON, 7'd11,  8'd1,   3'd2);
    send_event(OP_NOTE_ON, 7'd12,  8'd64,  3'd0);
    send_event(OP_NOTE_ON, 7'd13,  8'd127, 3'd7);
    send_event(OP_NOTE_ON, 7'd14,  8'd200, 3'd1);
  endtask

  // full table steals; a finished but held slot is retriggered; duplicate note
  task automatic test_steal_and_retrigger();
    send_event(OP_NOTE_ON,    7'd99, 8'd50,  3'd0);
    send_event(OP_VOICE_DONE, 7'd12, 8'd255, 3'd5);
    send_event(OP_NOTE_ON,    7'd12, 8'd90,  3'd0);
    send_event(OP_VOICE_DONE, 7'd0,  8'd0,   3'd1);
    send_event(OP_NOTE_ON,    7'd12, 8'd77,  3'd3);
  endtask

  // releases: several slots at once, no match, all notes off twice, refill
  task automatic test_release_paths();
    send_event(OP_NOTE_OFF,   7'd12,  8'd255, 3'd7);
    send_event(OP_NOTE_OFF,   7'd55,  8'd0,   3'd0);
    send_event(OP_NOTE_OFF,   7'd127, 8'd1,   3'd2);
    send_event(OP_VOICE_DONE, 7'd127, 8'd0,   3'd2);
    send_event(OP_VOICE_DONE, 7'd0,   8'd0,   3'd0);
    send_event(OP_VOICE_DONE, 7'd0,   8'd0,   3'd7);
    send_event(OP_ALL_OFF,    7'd127, 8'd255, 3'd7);
    send_event(OP_ALL_OFF,    7'd0,   8'd0,   3'd0);
    send_event(OP_NOTE_ON,    7'd40,  8'd255, 3'd0);
    send_event(OP_NOTE_ON,    7'd41,  8'd128, 3'd0);
    send_event(OP_NOTE_ON,    7'd42,  8'd129, 3'd0);
    send_event(OP_NOTE_ON,    7'd43,  8'd30,  3'd0);
  endtask

  // random events, mostly on a small pool of notes so retriggers and steals are common
  task automatic test_random_traffic(input int count);
    op_t        op;
    logic [6:0] note;
    logic [7:0] vel;
    logic [2:0] vid;
    int         roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      op = OP_NOTE_ON;
      else if (roll < 70) op = OP_NOTE_OFF;
      else if (roll < 96) op = OP_VOICE_DONE;
      else                op = OP_ALL_OFF;
      note = ($urandom_range(0, 3) != 0) ? 7'(36 + $urandom_range(0, 11))
                                         : 7'($urandom_range(0, 127));
      case ($urandom_range(0, 9))
        0:       vel = 8'd0;
        1:       vel = 8'd128;
        2:       vel = 8'($urandom_range(129, 255));
        default: vel = 8'($urandom_range(0, 255));
      endcase
      vid = 3'($urandom_range(0, 7));
      send_event(op, note, vel, vid);
    end
  endtask

  // receiver holds off for a long stretch while events keep coming
  task automatic test_output_hold();
    hold_token <= hold_token + 8'd1;
    test_random_traffic(40);
  endtask

  // sender stops until everything is back, several times
  task automatic test_drain_pauses();
    repeat (4) begin
      test_random_traffic(15);
      wait_for_idle();
    end
  endtask

  // sequence
  initial begin
    in_chan.valid    = 1'b0;
    in_chan.op       = OP_NOTE_ON;
    in_chan.note     = 7'd0;
    in_chan.velocity = 8'd0;
    in_chan.voice_id = 3'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_note_on_fill();
    test_steal_and_retrigger();
    test_release_paths();
    test_random_traffic(500);
    test_output_hold();
    test_drain_pauses();
    test_random_traffic(500);
    wait_for_idle();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
